// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is asserted.
`define ECB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ECB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ECB_ASSERT(lbl, clk, rstn, prop, msg)
`define ECB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/core/ecb_pkg.sv -----
package ecb_pkg;

  // Field widths
  localparam int OPCODE_W   = 2;
  localparam int LOCATION_W = 64;
  localparam int INDEX_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int MAP_BITS_W = 5;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  // Configuration register map (word index taken from paddr[2])
  localparam logic REG_MAP_INDEX_BITS = 1'b0;

  // Map size register limits and reset value
  localparam logic [MAP_BITS_W-1:0] MAP_BITS_MIN   = 5'd1;
  localparam logic [MAP_BITS_W-1:0] MAP_BITS_MAX   = 5'd16;
  localparam logic [MAP_BITS_W-1:0] MAP_BITS_RESET = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mul1;
    logic mul2;
    logic rd;
    logic upd;
    logic load_out;
  } ecb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ecb_stat_t;

endpackage

// ----- rtl/core/edge_coverage_bitmap.sv -----
// Edge coverage counter engine. Each item is a record (scramble the location,
// combine with the previous one, bump an 8-bit wrapping counter in the local
// or shadow map), a trace-history reset, or a counter read; every item yields
// exactly one result. Items are processed one at a time: after acceptance an
// item passes the two multiply stages that reduce the index modulo
// MAP_ENTRIES, the read and update steps of the counter memories (registered
// read) and the result load; the next item is taken in the idle state after it.
// A finished result waits in the output register while the next item is
// accepted. If that result is still stalled when the next one is ready, the
// next item holds at the result load until the output is taken.
// After reset the block clears both maps, one entry per cycle, before the first
// item is accepted (local entry 0 is set to one); configuration writes are
// taken during that sweep. map_index_bits sits at byte address 0.
module edge_coverage_bitmap #(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ecb_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [ecb_pkg::LOCATION_W-1:0]      location_i,
  input  logic                                map_select_i,
  input  logic [ecb_pkg::INDEX_W-1:0]         read_index_i,
  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ecb_pkg::INDEX_W-1:0]         entry_index_o,
  output logic [ecb_pkg::COUNT_W-1:0]         entry_count_o
);

  import ecb_pkg::*;

  logic [MAP_BITS_W-1:0] map_bits_q;
  ecb_cmd_t              cmd;
  ecb_stat_t             stat;

  // Map size register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bits_q <= MAP_BITS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAP_INDEX_BITS) begin
      map_bits_q <= pwdata[MAP_BITS_W-1:0];
    end
  end

  // Register read back
  assign prdata = (paddr[2] == REG_MAP_INDEX_BITS) ? 32'(map_bits_q) : '0;
  assign pready = 1'b1;

  ecb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ecb_dp #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .map_bits_i    (map_bits_q),
    .opcode_i      (opcode_i),
    .location_i    (location_i),
    .map_select_i  (map_select_i),
    .read_index_i  (read_index_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .entry_index_o (entry_index_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ----- rtl/core/ecb_ram.sv -----
module ecb_ram #(
  parameter int Width = 8,
  parameter int Depth = 65536,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ecb_ctrl.sv -----
`include "assert_macros.svh"

module ecb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ecb_pkg::ecb_stat_t stat_i,
  output ecb_pkg::ecb_cmd_t  cmd_o
);

  import ecb_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  // Run the clearing sweep, then sequence one item through index reduction, read, update and result
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register; start with the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `ECB_ASSERT(a_accept_starts_item, clk_i, rst_ni,
    cmd_o.accept |=> (state_q == ST_MUL1), "accepted item did not enter reduction")
  `ECB_ASSERT(a_single_command, clk_i, rst_ni,
    $onehot0({cmd_o.accept, cmd_o.clr_step, cmd_o.mul1, cmd_o.mul2, cmd_o.rd, cmd_o.upd,
              cmd_o.load_out}), "more than one datapath command at once")
  `ECB_ASSERT(a_ready_after_result, clk_i, rst_ni,
    cmd_o.load_out |=> !in_stall_o, "input not opened after result load")

endmodule

// ----- rtl/core/ecb_dp.sv -----
`include "assert_macros.svh"

module ecb_dp #(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ecb_pkg::ecb_cmd_t                    cmd_i,
  output ecb_pkg::ecb_stat_t                   stat_o,
  input  logic [ecb_pkg::MAP_BITS_W-1:0]      map_bits_i,
  input  logic [ecb_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [ecb_pkg::LOCATION_W-1:0]      location_i,
  input  logic                                map_select_i,
  input  logic [ecb_pkg::INDEX_W-1:0]         read_index_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [ecb_pkg::INDEX_W-1:0]         entry_index_o,
  output logic [ecb_pkg::COUNT_W-1:0]         entry_count_o
);

  import ecb_pkg::*;

  localparam int IdxW = $clog2(MAP_ENTRIES);
  // ceil(2^32 / MAP_ENTRIES): exact floor quotient for any 16-bit index
  localparam logic [31:0] Recip = 32'(((64'd1 << 32) + 64'(MAP_ENTRIES) - 64'd1)
                                      / 64'(MAP_ENTRIES));
  localparam logic [16:0] Entries = 17'(MAP_ENTRIES);

  logic [INDEX_W-1:0]    prior_q;
  logic [OPCODE_W-1:0]   op_q;
  logic                  sel_q;
  logic [INDEX_W-1:0]    raw_q;
  logic [47:0]           prod_q;
  logic [INDEX_W-1:0]    qm_q;
  logic [IdxW-1:0]       idx_q;
  logic [IdxW-1:0]       clr_addr_q;
  logic [IdxW-1:0]       res_idx_q;
  logic [COUNT_W-1:0]    res_cnt_q;
  logic                  out_valid_q;
  logic [INDEX_W-1:0]    out_idx_q;
  logic [COUNT_W-1:0]    out_cnt_q;

  logic [MAP_BITS_W-1:0] bits_c;
  logic [INDEX_W-1:0]    mask_c;
  logic [16:0]           scr_c;
  logic [INDEX_W-1:0]    raw_d;
  logic [INDEX_W-1:0]    idx_full_c;
  logic [COUNT_W-1:0]    rdata_c;
  logic [COUNT_W-1:0]    cnt_c;
  logic                  is_record_c;
  logic                  we_lo, we_sh;
  logic [IdxW-1:0]       waddr_c;
  logic [COUNT_W-1:0]    wdata_lo, wdata_sh;
  logic [COUNT_W-1:0]    rdata_lo, rdata_sh;

  // Clamp map size and form the index mask
  always_comb begin
    bits_c = map_bits_i;
    if (bits_c < MAP_BITS_MIN) begin
      bits_c = MAP_BITS_MIN;
    end
    if (bits_c > MAP_BITS_MAX) begin
      bits_c = MAP_BITS_MAX;
    end
    mask_c = INDEX_W'((17'd1 << bits_c) - 17'd1);
  end

  // Scramble the low location bits: (loc >> 4) ^ (loc << 8), bits 16..0
  assign scr_c = location_i[20:4] ^ {location_i[8:0], 8'b0};

  // Select the raw counter index for the incoming item
  always_comb begin
    case (opcode_i)
      OP_RECORD: raw_d = (scr_c[15:0] ^ prior_q) & mask_c;
      OP_READ:   raw_d = read_index_i;
      default:   raw_d = '0;
    endcase
  end

  // Track the previous location
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
    end else if (cmd_i.accept) begin
      if (opcode_i == OP_RECORD) begin
        prior_q <= scr_c[16:1];
      end else if (opcode_i == OP_CLEAR) begin
        prior_q <= '0;
      end
    end
  end

  // Capture the item and reduce the index modulo the map depth
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= opcode_i;
      sel_q <= map_select_i;
      raw_q <= raw_d;
    end
    if (cmd_i.mul1) begin
      prod_q <= raw_q * Recip;
    end
    if (cmd_i.mul2) begin
      qm_q <= INDEX_W'(prod_q[47:32] * Entries);
    end
    if (cmd_i.rd) begin
      idx_q <= idx_full_c[IdxW-1:0];
    end
  end

  assign idx_full_c = raw_q - qm_q;

  // Step the clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Increment or pass the counter read back
  assign is_record_c = (op_q == OP_RECORD);
  assign rdata_c     = sel_q ? rdata_sh : rdata_lo;
  assign cnt_c       = is_record_c ? rdata_c + 1'b1 : rdata_c;

  // Write ports: clearing sweep or counter update
  always_comb begin
    if (cmd_i.clr_step) begin
      we_lo    = 1'b1;
      we_sh    = 1'b1;
      waddr_c  = clr_addr_q;
      wdata_lo = (clr_addr_q == '0) ? COUNT_W'(1) : '0;
      wdata_sh = '0;
    end else begin
      we_lo    = cmd_i.upd && is_record_c && !sel_q;
      we_sh    = cmd_i.upd && is_record_c && sel_q;
      waddr_c  = idx_q;
      wdata_lo = cnt_c;
      wdata_sh = cnt_c;
    end
  end

  ecb_ram #(
    .Width (COUNT_W),
    .Depth (MAP_ENTRIES)
  ) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (we_lo),
    .waddr_i (waddr_c),
    .wdata_i (wdata_lo),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_full_c[IdxW-1:0]),
    .rdata_o (rdata_lo)
  );

  ecb_ram #(
    .Width (COUNT_W),
    .Depth (MAP_ENTRIES)
  ) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (we_sh),
    .waddr_i (waddr_c),
    .wdata_i (wdata_sh),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_full_c[IdxW-1:0]),
    .rdata_o (rdata_sh)
  );

  // Hold the result of the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      if (is_record_c || op_q == OP_READ) begin
        res_idx_q <= idx_q;
        res_cnt_q <= cnt_c;
      end else begin
        res_idx_q <= '0;
        res_cnt_q <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_idx_q <= INDEX_W'(res_idx_q);
      out_cnt_q <= res_cnt_q;
    end
  end

  assign stat_o.clr_last = (clr_addr_q == IdxW'(MAP_ENTRIES - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_idx_q;
  assign entry_count_o = out_cnt_q;

  `ECB_ASSERT(a_index_in_range, clk_i, rst_ni,
    cmd_i.rd |-> ({1'b0, idx_full_c} < Entries), "reduced index not below map depth")
  `ECB_ASSERT(a_dual_write_only_clear, clk_i, rst_ni,
    (we_lo && we_sh) |-> cmd_i.clr_step, "both maps written outside clearing sweep")

endmodule
